// File: rtl/rfa_pkg.sv
// Shared widths, codes, command set and helper function for the rational fraction ALU.
package rfa_pkg;

   localparam int DATA_W   = 32;
   localparam int DEN_W    = 31;
   localparam int WIDE_W   = 64;
   localparam int MODE_W   = 2;
   localparam int ERR_W    = 2;
   localparam int GK_W     = 7;
   localparam int DIV_STEPS = WIDE_W;
   localparam int DCNT_W   = $clog2(DIV_STEPS + 1);

   localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MUL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAC = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_ZERO_DEN = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

   localparam logic [WIDE_W-1:0] LIM_POS = 64'h0000_0000_7FFF_FFFF;
   localparam logic [WIDE_W-1:0] LIM_NEG = 64'h0000_0000_8000_0000;

   typedef logic [4:0] cmd_type;

   localparam cmd_type CMD_NOP      = 5'd0;
   localparam cmd_type CMD_LOAD     = 5'd1;
   localparam cmd_type CMD_RA       = 5'd2;
   localparam cmd_type CMD_RB       = 5'd3;
   localparam cmd_type CMD_SA       = 5'd4;
   localparam cmd_type CMD_SB       = 5'd5;
   localparam cmd_type CMD_ZERO_R   = 5'd6;
   localparam cmd_type CMD_GCD_R    = 5'd7;
   localparam cmd_type CMD_GCD_D    = 5'd8;
   localparam cmd_type CMD_GCD_STEP = 5'd9;
   localparam cmd_type CMD_GCD_FIN  = 5'd10;
   localparam cmd_type CMD_DIV_M    = 5'd11;
   localparam cmd_type CMD_DIV_D    = 5'd12;
   localparam cmd_type CMD_DIV_A    = 5'd13;
   localparam cmd_type CMD_DIV_B    = 5'd14;
   localparam cmd_type CMD_DIV_STEP = 5'd15;
   localparam cmd_type CMD_PUT_M    = 5'd16;
   localparam cmd_type CMD_PUT_D    = 5'd17;
   localparam cmd_type CMD_PUT_A    = 5'd18;
   localparam cmd_type CMD_PUT_B    = 5'd19;
   localparam cmd_type CMD_MUL_NUM  = 5'd20;
   localparam cmd_type CMD_MUL_DEN  = 5'd21;
   localparam cmd_type CMD_MUL_TA   = 5'd22;
   localparam cmd_type CMD_MUL_TB   = 5'd23;
   localparam cmd_type CMD_MUL_L    = 5'd24;
   localparam cmd_type CMD_COMBINE  = 5'd25;
   localparam cmd_type CMD_ACC_AB   = 5'd26;
   localparam cmd_type CMD_ERR2     = 5'd27;
   localparam cmd_type CMD_FINISH   = 5'd28;

   typedef struct packed {
      logic err_zero;
      logic mode_add;
      logic mode_mac;
      logic r_zero;
      logic fits;
      logic gcd_done;
      logic div_done;
   } status_type;

   function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
      mag32 = v[DATA_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// File: rtl/rfa_ifs.sv
// Request and response channel interfaces.
interface rfa_req_if;
   logic                                valid;
   logic                                ready;
   logic [rfa_pkg::MODE_W-1:0]          mode;
   logic signed [rfa_pkg::DATA_W-1:0]   a_num;
   logic signed [rfa_pkg::DATA_W-1:0]   a_den;
   logic signed [rfa_pkg::DATA_W-1:0]   b_num;
   logic signed [rfa_pkg::DATA_W-1:0]   b_den;
   logic                                last_term;

   modport source(output valid, mode, a_num, a_den, b_num, b_den, last_term, input ready);
   modport sink(input valid, mode, a_num, a_den, b_num, b_den, last_term, output ready);
endinterface

interface rfa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rfa_pkg::DATA_W-1:0]   res_num;
   logic [rfa_pkg::DEN_W-1:0]           res_den;
   logic [rfa_pkg::ERR_W-1:0]           error;

   modport source(output valid, res_num, res_den, error, input ready);
   modport sink(input valid, res_num, res_den, error, output ready);
endinterface

// File: rtl/rfa_dp.sv
// Datapath: fraction registers, binary gcd, restoring divider, shared multiplier, accumulator.
module rfa_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  rfa_pkg::cmd_type                  cmd,
   output rfa_pkg::status_type               status,
   input  logic [rfa_pkg::MODE_W-1:0]        req_mode,
   input  logic [rfa_pkg::DATA_W-1:0]        req_a_num,
   input  logic [rfa_pkg::DATA_W-1:0]        req_a_den,
   input  logic [rfa_pkg::DATA_W-1:0]        req_b_num,
   input  logic [rfa_pkg::DATA_W-1:0]        req_b_den,
   input  logic                              req_last_term,
   output logic signed [rfa_pkg::DATA_W-1:0] rsp_res_num,
   output logic [rfa_pkg::DEN_W-1:0]         rsp_res_den,
   output logic [rfa_pkg::ERR_W-1:0]         rsp_error
);

   localparam int DW = rfa_pkg::DATA_W;
   localparam int WW = rfa_pkg::WIDE_W;

   logic [rfa_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic                       last_ff, last_in;
   logic [rfa_pkg::ERR_W-1:0]  err_ff, err_in;
   logic [DW-1:0]              am_ff, am_in, ad_ff, ad_in, bm_ff, bm_in, bd_ff, bd_in;
   logic                       aneg_ff, aneg_in, bneg_ff, bneg_in;
   logic [WW-1:0]              rm_ff, rm_in, rd_ff, rd_in;
   logic                       rneg_ff, rneg_in;
   logic [WW-1:0]              gu_ff, gu_in, gv_ff, gv_in, g_ff, g_in;
   logic [rfa_pkg::GK_W-1:0]   gk_ff, gk_in;
   logic [WW-1:0]              dq_ff, dq_in, drem_ff, drem_in;
   logic [rfa_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [DW-1:0]              adg_ff, adg_in, bdg_ff, bdg_in;
   logic [WW-1:0]              ta_ff, ta_in, tb_ff, tb_in;
   logic [DW-1:0]              acc_num_ff, acc_num_in, acc_den_ff, acc_den_in;
   logic signed [DW-1:0]       res_num_ff, res_num_in;
   logic [rfa_pkg::DEN_W-1:0]  res_den_ff, res_den_in;
   logic [rfa_pkg::ERR_W-1:0]  res_err_ff, res_err_in;

   logic [DW-1:0]  mul_x, mul_y;
   logic [WW-1:0]  prod;
   logic [WW:0]    div_t, div_sub;
   logic [DW-1:0]  r_bits;

   assign prod    = {{(WW-DW){1'b0}}, mul_x} * {{(WW-DW){1'b0}}, mul_y};
   assign div_t   = {drem_ff, dq_ff[WW-1]};
   assign div_sub = div_t - {1'b0, g_ff};
   assign r_bits  = rneg_ff ? (~rm_ff[DW-1:0] + 1'b1) : rm_ff[DW-1:0];

   always_comb begin
      unique case (cmd)
         rfa_pkg::CMD_MUL_NUM: begin mul_x = am_ff;  mul_y = bm_ff;  end
         rfa_pkg::CMD_MUL_DEN: begin mul_x = ad_ff;  mul_y = bd_ff;  end
         rfa_pkg::CMD_MUL_TA:  begin mul_x = am_ff;  mul_y = bdg_ff; end
         rfa_pkg::CMD_MUL_TB:  begin mul_x = bm_ff;  mul_y = adg_ff; end
         default:              begin mul_x = adg_ff; mul_y = bd_ff;  end
      endcase
   end

   always_comb begin
      mode_in = mode_ff; last_in = last_ff; err_in = err_ff;
      am_in = am_ff; ad_in = ad_ff; bm_in = bm_ff; bd_in = bd_ff;
      aneg_in = aneg_ff; bneg_in = bneg_ff;
      rm_in = rm_ff; rd_in = rd_ff; rneg_in = rneg_ff;
      gu_in = gu_ff; gv_in = gv_ff; gk_in = gk_ff; g_in = g_ff;
      dq_in = dq_ff; drem_in = drem_ff; dcnt_in = dcnt_ff;
      adg_in = adg_ff; bdg_in = bdg_ff; ta_in = ta_ff; tb_in = tb_ff;
      acc_num_in = acc_num_ff; acc_den_in = acc_den_ff;
      res_num_in = res_num_ff; res_den_in = res_den_ff; res_err_in = res_err_ff;
      unique case (cmd)
         rfa_pkg::CMD_LOAD: begin
            mode_in = req_mode;
            last_in = req_last_term;
            err_in  = (req_a_den == '0 || req_b_den == '0) ? rfa_pkg::ERR_ZERO_DEN
                                                            : rfa_pkg::ERR_NONE;
            am_in   = rfa_pkg::mag32(req_a_num);
            ad_in   = rfa_pkg::mag32(req_a_den);
            bm_in   = rfa_pkg::mag32(req_b_num);
            bd_in   = rfa_pkg::mag32(req_b_den);
            aneg_in = (req_a_num != '0) && (req_a_num[DW-1] != req_a_den[DW-1]);
            bneg_in = (req_b_num != '0) && (req_b_num[DW-1] != req_b_den[DW-1]);
         end
         rfa_pkg::CMD_RA: begin
            rm_in = {{(WW-DW){1'b0}}, am_ff};
            rd_in = {{(WW-DW){1'b0}}, ad_ff};
            rneg_in = aneg_ff;
         end
         rfa_pkg::CMD_RB: begin
            rm_in = {{(WW-DW){1'b0}}, bm_ff};
            rd_in = {{(WW-DW){1'b0}}, bd_ff};
            rneg_in = bneg_ff;
         end
         rfa_pkg::CMD_SA: begin
            am_in = rm_ff[DW-1:0]; ad_in = rd_ff[DW-1:0]; aneg_in = rneg_ff;
         end
         rfa_pkg::CMD_SB: begin
            bm_in = rm_ff[DW-1:0]; bd_in = rd_ff[DW-1:0]; bneg_in = rneg_ff;
         end
         rfa_pkg::CMD_ZERO_R: begin
            rd_in = {{(WW-1){1'b0}}, 1'b1};
            rneg_in = 1'b0;
         end
         rfa_pkg::CMD_GCD_R: begin
            gu_in = rm_ff; gv_in = rd_ff; gk_in = '0;
         end
         rfa_pkg::CMD_GCD_D: begin
            gu_in = {{(WW-DW){1'b0}}, ad_ff};
            gv_in = {{(WW-DW){1'b0}}, bd_ff};
            gk_in = '0;
         end
         rfa_pkg::CMD_GCD_STEP: begin
            priority if (!gu_ff[0] && !gv_ff[0]) begin
               gu_in = gu_ff >> 1;
               gv_in = gv_ff >> 1;
               gk_in = gk_ff + 1'b1;
            end else if (!gu_ff[0]) begin
               gu_in = gu_ff >> 1;
            end else if (!gv_ff[0]) begin
               gv_in = gv_ff >> 1;
            end else if (gu_ff >= gv_ff) begin
               gu_in = (gu_ff - gv_ff) >> 1;
            end else begin
               gv_in = (gv_ff - gu_ff) >> 1;
            end
         end
         rfa_pkg::CMD_GCD_FIN: g_in = (gu_ff | gv_ff) << gk_ff;
         rfa_pkg::CMD_DIV_M: begin
            dq_in = rm_ff; drem_in = '0; dcnt_in = rfa_pkg::DCNT_W'(rfa_pkg::DIV_STEPS);
         end
         rfa_pkg::CMD_DIV_D: begin
            dq_in = rd_ff; drem_in = '0; dcnt_in = rfa_pkg::DCNT_W'(rfa_pkg::DIV_STEPS);
         end
         rfa_pkg::CMD_DIV_A: begin
            dq_in = {{(WW-DW){1'b0}}, ad_ff}; drem_in = '0;
            dcnt_in = rfa_pkg::DCNT_W'(rfa_pkg::DIV_STEPS);
         end
         rfa_pkg::CMD_DIV_B: begin
            dq_in = {{(WW-DW){1'b0}}, bd_ff}; drem_in = '0;
            dcnt_in = rfa_pkg::DCNT_W'(rfa_pkg::DIV_STEPS);
         end
         rfa_pkg::CMD_DIV_STEP: begin
            if (!div_sub[WW]) begin
               drem_in = div_sub[WW-1:0];
               dq_in   = {dq_ff[WW-2:0], 1'b1};
            end else begin
               drem_in = div_t[WW-1:0];
               dq_in   = {dq_ff[WW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
         end
         rfa_pkg::CMD_PUT_M:   rm_in = dq_ff;
         rfa_pkg::CMD_PUT_D:   rd_in = dq_ff;
         rfa_pkg::CMD_PUT_A:   adg_in = dq_ff[DW-1:0];
         rfa_pkg::CMD_PUT_B:   bdg_in = dq_ff[DW-1:0];
         rfa_pkg::CMD_MUL_NUM: begin
            rm_in = prod; rneg_in = aneg_ff ^ bneg_ff;
         end
         rfa_pkg::CMD_MUL_DEN: rd_in = prod;
         rfa_pkg::CMD_MUL_TA:  ta_in = prod;
         rfa_pkg::CMD_MUL_TB:  tb_in = prod;
         rfa_pkg::CMD_MUL_L:   rd_in = prod;
         rfa_pkg::CMD_COMBINE: begin
            priority if (aneg_ff == bneg_ff) begin
               rm_in = ta_ff + tb_ff; rneg_in = aneg_ff;
            end else if (ta_ff >= tb_ff) begin
               rm_in = ta_ff - tb_ff; rneg_in = aneg_ff;
            end else begin
               rm_in = tb_ff - ta_ff; rneg_in = bneg_ff;
            end
         end
         rfa_pkg::CMD_ACC_AB: begin
            am_in = rfa_pkg::mag32(acc_num_ff);
            aneg_in = acc_num_ff[DW-1];
            ad_in = acc_den_ff;
            bm_in = rm_ff[DW-1:0]; bd_in = rd_ff[DW-1:0]; bneg_in = rneg_ff;
         end
         rfa_pkg::CMD_ERR2: err_in = rfa_pkg::ERR_OVERFLOW;
         rfa_pkg::CMD_FINISH: begin
            res_err_in = err_ff;
            if (err_ff != rfa_pkg::ERR_NONE) begin
               res_num_in = '0;
               res_den_in = rfa_pkg::DEN_W'(1);
            end else begin
               res_num_in = r_bits;
               res_den_in = rd_ff[rfa_pkg::DEN_W-1:0];
            end
            if (mode_ff == rfa_pkg::MODE_MAC) begin
               if (err_ff == rfa_pkg::ERR_NONE) begin
                  acc_num_in = r_bits;
                  acc_den_in = rd_ff[DW-1:0];
               end
               if (last_ff) begin
                  acc_num_in = '0;
                  acc_den_in = DW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_num_ff <= '0;
         acc_den_ff <= DW'(1);
      end else begin
         acc_num_ff <= acc_num_in;
         acc_den_ff <= acc_den_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in; last_ff <= last_in; err_ff <= err_in;
      am_ff <= am_in; ad_ff <= ad_in; bm_ff <= bm_in; bd_ff <= bd_in;
      aneg_ff <= aneg_in; bneg_ff <= bneg_in;
      rm_ff <= rm_in; rd_ff <= rd_in; rneg_ff <= rneg_in;
      gu_ff <= gu_in; gv_ff <= gv_in; gk_ff <= gk_in; g_ff <= g_in;
      dq_ff <= dq_in; drem_ff <= drem_in; dcnt_ff <= dcnt_in;
      adg_ff <= adg_in; bdg_ff <= bdg_in; ta_ff <= ta_in; tb_ff <= tb_in;
      res_num_ff <= res_num_in; res_den_ff <= res_den_in; res_err_ff <= res_err_in;
   end

   assign status.err_zero = (err_ff == rfa_pkg::ERR_ZERO_DEN);
   assign status.mode_add = (mode_ff == rfa_pkg::MODE_ADD);
   assign status.mode_mac = (mode_ff == rfa_pkg::MODE_MAC);
   assign status.r_zero   = (rm_ff == '0);
   assign status.fits     = (rd_ff != '0) && (rd_ff <= rfa_pkg::LIM_POS) &&
                            (rneg_ff ? (rm_ff <= rfa_pkg::LIM_NEG) : (rm_ff <= rfa_pkg::LIM_POS));
   assign status.gcd_done = (gu_ff == '0) || (gv_ff == '0);
   assign status.div_done = (dcnt_ff == '0);

   assign rsp_res_num = res_num_ff;
   assign rsp_res_den = res_den_ff;
   assign rsp_error   = res_err_ff;

endmodule

// File: rtl/rfa_ctrl.sv
// Controller: sequences reduce, gcd, divide and multiply steps and owns the handshakes.
module rfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rfa_pkg::cmd_type    cmd,
   input  rfa_pkg::status_type status
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_RA   = 5'd1;
   localparam logic [4:0] S_SA   = 5'd2;
   localparam logic [4:0] S_RB   = 5'd3;
   localparam logic [4:0] S_SB   = 5'd4;
   localparam logic [4:0] S_RED  = 5'd5;
   localparam logic [4:0] S_RGS  = 5'd6;
   localparam logic [4:0] S_RDM  = 5'd7;
   localparam logic [4:0] S_RDMS = 5'd8;
   localparam logic [4:0] S_RDD  = 5'd9;
   localparam logic [4:0] S_RDDS = 5'd10;
   localparam logic [4:0] S_AG   = 5'd11;
   localparam logic [4:0] S_AGS  = 5'd12;
   localparam logic [4:0] S_ADA  = 5'd13;
   localparam logic [4:0] S_ADAS = 5'd14;
   localparam logic [4:0] S_ADB  = 5'd15;
   localparam logic [4:0] S_ADBS = 5'd16;
   localparam logic [4:0] S_MTA  = 5'd17;
   localparam logic [4:0] S_MTB  = 5'd18;
   localparam logic [4:0] S_ML   = 5'd19;
   localparam logic [4:0] S_CMB  = 5'd20;
   localparam logic [4:0] S_MN   = 5'd21;
   localparam logic [4:0] S_MD   = 5'd22;
   localparam logic [4:0] S_PCHK = 5'd23;
   localparam logic [4:0] S_CHK  = 5'd24;
   localparam logic [4:0] S_FIN  = 5'd25;

   logic [4:0] state_ff, state_in, ret_ff, ret_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = rfa_pkg::CMD_NOP;
      req_ready = 1'b0;
      valid_in  = rsp_ready ? 1'b0 : valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd = rfa_pkg::CMD_LOAD;
               state_in = S_RA;
            end
         end
         S_RA: begin
            if (status.err_zero) begin
               state_in = S_FIN;
            end else begin
               cmd = rfa_pkg::CMD_RA; ret_in = S_SA; state_in = S_RED;
            end
         end
         S_SA: begin cmd = rfa_pkg::CMD_SA; state_in = S_RB; end
         S_RB: begin cmd = rfa_pkg::CMD_RB; ret_in = S_SB; state_in = S_RED; end
         S_SB: begin
            cmd = rfa_pkg::CMD_SB;
            state_in = status.mode_add ? S_AG : S_MN;
         end
         S_RED: begin
            if (status.r_zero) begin
               cmd = rfa_pkg::CMD_ZERO_R; state_in = ret_ff;
            end else begin
               cmd = rfa_pkg::CMD_GCD_R; state_in = S_RGS;
            end
         end
         S_RGS: begin
            if (status.gcd_done) begin
               cmd = rfa_pkg::CMD_GCD_FIN; state_in = S_RDM;
            end else begin
               cmd = rfa_pkg::CMD_GCD_STEP;
            end
         end
         S_RDM: begin cmd = rfa_pkg::CMD_DIV_M; state_in = S_RDMS; end
         S_RDMS: begin
            if (status.div_done) begin
               cmd = rfa_pkg::CMD_PUT_M; state_in = S_RDD;
            end else begin
               cmd = rfa_pkg::CMD_DIV_STEP;
            end
         end
         S_RDD: begin cmd = rfa_pkg::CMD_DIV_D; state_in = S_RDDS; end
         S_RDDS: begin
            if (status.div_done) begin
               cmd = rfa_pkg::CMD_PUT_D; state_in = ret_ff;
            end else begin
               cmd = rfa_pkg::CMD_DIV_STEP;
            end
         end
         S_AG: begin cmd = rfa_pkg::CMD_GCD_D; state_in = S_AGS; end
         S_AGS: begin
            if (status.gcd_done) begin
               cmd = rfa_pkg::CMD_GCD_FIN; state_in = S_ADA;
            end else begin
               cmd = rfa_pkg::CMD_GCD_STEP;
            end
         end
         S_ADA: begin cmd = rfa_pkg::CMD_DIV_A; state_in = S_ADAS; end
         S_ADAS: begin
            if (status.div_done) begin
               cmd = rfa_pkg::CMD_PUT_A; state_in = S_ADB;
            end else begin
               cmd = rfa_pkg::CMD_DIV_STEP;
            end
         end
         S_ADB: begin cmd = rfa_pkg::CMD_DIV_B; state_in = S_ADBS; end
         S_ADBS: begin
            if (status.div_done) begin
               cmd = rfa_pkg::CMD_PUT_B; state_in = S_MTA;
            end else begin
               cmd = rfa_pkg::CMD_DIV_STEP;
            end
         end
         S_MTA: begin cmd = rfa_pkg::CMD_MUL_TA; state_in = S_MTB; end
         S_MTB: begin cmd = rfa_pkg::CMD_MUL_TB; state_in = S_ML; end
         S_ML:  begin cmd = rfa_pkg::CMD_MUL_L;  state_in = S_CMB; end
         S_CMB: begin
            cmd = rfa_pkg::CMD_COMBINE; ret_in = S_CHK; state_in = S_RED;
         end
         S_MN: begin cmd = rfa_pkg::CMD_MUL_NUM; state_in = S_MD; end
         S_MD: begin
            cmd = rfa_pkg::CMD_MUL_DEN;
            ret_in = status.mode_mac ? S_PCHK : S_CHK;
            state_in = S_RED;
         end
         S_PCHK: begin
            if (!status.fits) begin
               cmd = rfa_pkg::CMD_ERR2; state_in = S_FIN;
            end else begin
               cmd = rfa_pkg::CMD_ACC_AB; state_in = S_AG;
            end
         end
         S_CHK: begin
            if (!status.fits) cmd = rfa_pkg::CMD_ERR2;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd = rfa_pkg::CMD_FINISH;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/rational_fraction_alu.sv
// Top level of the rational fraction ALU: add, multiply and multiply-accumulate on fractions.
//
//   channel   direction  handshake       payload
//   req_bus   in         valid / ready   mode, a_num, a_den, b_num, b_den, last_term
//   rsp_bus   out        valid / ready   res_num, res_den, error
//
// One request at a time; its run time is set by the binary gcd
// (one shift or subtract a cycle over 64 bits) and the 64-step restoring divider,
// run twice per reduction. A zero numerator skips its reduction.
// A zero denominator goes straight to the finish.
// Synchronous active-high reset clears the controller and sets the accumulator to 0/1.
// A finished result waits in the output register; the next request is taken meanwhile,
// and its result waits for that register to drain.
module rational_fraction_alu (
   input  logic        clock,
   input  logic        reset,
   rfa_req_if.sink     req_bus,
   rfa_rsp_if.source   rsp_bus
);

   rfa_pkg::cmd_type    cmd;
   rfa_pkg::status_type status;

   rfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   rfa_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_mode      (req_bus.mode),
      .req_a_num     (req_bus.a_num),
      .req_a_den     (req_bus.a_den),
      .req_b_num     (req_bus.b_num),
      .req_b_den     (req_bus.b_den),
      .req_last_term (req_bus.last_term),
      .rsp_res_num   (rsp_bus.res_num),
      .rsp_res_den   (rsp_bus.res_den),
      .rsp_error     (rsp_bus.error)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.error != rfa_pkg::ERR_NONE |->
         rsp_bus.res_num == '0 && rsp_bus.res_den == rfa_pkg::DEN_W'(1))
      else $error("error result not 0/1");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.error == rfa_pkg::ERR_NONE |-> rsp_bus.res_den != '0)
      else $error("zero denominator on good result");

   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while busy");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the rational fraction ALU: directed table, then random requests.
module tb_top;

   typedef struct {
      logic [rfa_pkg::MODE_W-1:0] mode;
      logic [31:0]                an, ad, bn, bd;
      logic                       last;
      logic                       chk;
      logic [31:0]                en;
      logic [30:0]                ed;
      logic [rfa_pkg::ERR_W-1:0]  ee;
   } row_type;

   typedef struct {
      logic [31:0]               num;
      logic [30:0]               den;
      logic [rfa_pkg::ERR_W-1:0] err;
   } res_type;

   typedef struct {
      bit          neg;
      logic [63:0] mag;
      logic [63:0] den;
   } frac_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   rfa_req_if req_bus ();
   rfa_rsp_if rsp_bus ();

   rational_fraction_alu dut (.clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus));

   always #5 clock = ~clock;

   logic [31:0] acc_n = 32'd0;
   logic [31:0] acc_d = 32'd1;
   res_type     pending[$];
   int          errors = 0;
   int          req_idle = 0;
   int          rsp_stall = 0;

   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic frac_type to_frac(logic [31:0] n, logic [31:0] d);
      frac_type f;
      f.mag = {32'd0, n[31] ? (~n + 32'd1) : n};
      f.den = {32'd0, d[31] ? (~d + 32'd1) : d};
      if (n[31] && n == 32'h8000_0000) f.mag = 64'h8000_0000;
      if (d[31] && d == 32'h8000_0000) f.den = 64'h8000_0000;
      f.neg = (f.mag != 0) && (n[31] != d[31]);
      return f;
   endfunction

   function automatic frac_type simplify(frac_type f);
      logic [63:0] g;
      g = gcd64(f.mag, f.den);
      if (g != 0) begin
         f.mag = f.mag / g;
         f.den = f.den / g;
      end
      if (f.mag == 0) begin
         f.den = 1;
         f.neg = 0;
      end
      return f;
   endfunction

   function automatic bit in_range(frac_type f);
      if (f.den > rfa_pkg::LIM_POS || f.den == 0) return 0;
      return f.neg ? (f.mag <= rfa_pkg::LIM_NEG) : (f.mag <= rfa_pkg::LIM_POS);
   endfunction

   function automatic frac_type frac_mul(frac_type a, frac_type b);
      frac_type r;
      r.mag = a.mag * b.mag;
      r.den = a.den * b.den;
      r.neg = a.neg != b.neg;
      return simplify(r);
   endfunction

   function automatic frac_type frac_add(frac_type a, frac_type b);
      frac_type r;
      logic [63:0] g, l, ta, tb;
      g = gcd64(a.den, b.den);
      l = (a.den / g) * b.den;
      ta = a.mag * (l / a.den);
      tb = b.mag * (l / b.den);
      if (a.neg == b.neg) begin
         r.mag = ta + tb;
         r.neg = a.neg;
      end else if (ta >= tb) begin
         r.mag = ta - tb;
         r.neg = a.neg;
      end else begin
         r.mag = tb - ta;
         r.neg = b.neg;
      end
      r.den = l;
      return simplify(r);
   endfunction

   function automatic res_type compute_fraction(row_type q);
      res_type  o;
      frac_type a, b, p, r;
      logic [rfa_pkg::ERR_W-1:0] e;
      logic [31:0] nb;
      e = rfa_pkg::ERR_NONE;
      r.neg = 0;
      r.mag = 0;
      r.den = 1;
      if (q.ad == 0 || q.bd == 0) begin
         e = rfa_pkg::ERR_ZERO_DEN;
      end else begin
         a = simplify(to_frac(q.an, q.ad));
         b = simplify(to_frac(q.bn, q.bd));
         if (q.mode == rfa_pkg::MODE_ADD) begin
            r = frac_add(a, b);
            if (!in_range(r)) e = rfa_pkg::ERR_OVERFLOW;
         end else if (q.mode == rfa_pkg::MODE_MAC) begin
            p = frac_mul(a, b);
            if (!in_range(p)) e = rfa_pkg::ERR_OVERFLOW;
            else begin
               r = frac_add(simplify(to_frac(acc_n, acc_d == 0 ? 32'd1 : acc_d)), p);
               if (!in_range(r)) e = rfa_pkg::ERR_OVERFLOW;
            end
         end else begin
            r = frac_mul(a, b);
            if (!in_range(r)) e = rfa_pkg::ERR_OVERFLOW;
         end
      end
      if (e != rfa_pkg::ERR_NONE) begin
         r.neg = 0;
         r.mag = 0;
         r.den = 1;
      end
      nb = r.neg ? (32'd0 - r.mag[31:0]) : r.mag[31:0];
      if (e == rfa_pkg::ERR_NONE && q.mode == rfa_pkg::MODE_MAC) begin
         acc_n = nb;
         acc_d = r.den[31:0];
      end
      if (q.mode == rfa_pkg::MODE_MAC && q.last) begin
         acc_n = 32'd0;
         acc_d = 32'd1;
      end
      o.num = nb;
      o.den = r.den[30:0];
      o.err = e;
      return o;
   endfunction

   always @(posedge clock) begin
      res_type ex;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending.size() == 0) begin
            $display("%0t unexpected response num=%h den=%h err=%0d", $time,
                     rsp_bus.res_num, rsp_bus.res_den, rsp_bus.error);
            errors++;
         end else begin
            ex = pending.pop_front();
            if (rsp_bus.res_num !== ex.num || rsp_bus.res_den !== ex.den ||
                rsp_bus.error !== ex.err) begin
               $display("%0t mismatch expected %h/%h err=%0d actual %h/%h err=%0d", $time,
                        ex.num, ex.den, ex.err, rsp_bus.res_num, rsp_bus.res_den,
                        rsp_bus.error);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 0;
      else rsp_bus.ready <= ($urandom_range(99) >= rsp_stall);
   end

   function automatic logic [31:0] rand_val();
      case ($urandom_range(5))
         0: return $urandom_range(9);
         1: return -$urandom_range(9);
         2: return $urandom_range(1000) - 500;
         3: return $urandom();
         4: return ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000) + $urandom_range(2);
         default: return $urandom_range(65535) - 32768;
      endcase
   endfunction

   task automatic send_request(row_type q);
      res_type ex;
      while ($urandom_range(99) < req_idle) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.mode <= q.mode;
      req_bus.a_num <= q.an;
      req_bus.a_den <= q.ad;
      req_bus.b_num <= q.bn;
      req_bus.b_den <= q.bd;
      req_bus.last_term <= q.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      ex = compute_fraction(q);
      if (q.chk && (ex.num !== q.en || ex.den !== q.ed || ex.err !== q.ee))
         ex = '{q.en, q.ed, q.ee};
      pending.push_back(ex);
      @(negedge clock);
   endtask

   row_type table_rows[$];

   initial begin
      row_type q;
      int      k;
      req_bus.valid = 0;
      req_bus.mode = rfa_pkg::MODE_ADD;
      req_bus.a_num = 0;
      req_bus.a_den = 1;
      req_bus.b_num = 0;
      req_bus.b_den = 1;
      req_bus.last_term = 0;
      table_rows = '{
         '{rfa_pkg::MODE_ADD, 0, 1, 0, 1, 0, 1, 0, 1, rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_MAC, 0, 1, 0, 1, 0, 1, 0, 1, rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_ADD, 1, 2, 1, 3, 0, 1, 5, 6, rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_MUL, 2, 4, 3, 9, 0, 1, 1, 6, rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_MUL, 1, 0, 1, 1, 0, 1, 0, 1, rfa_pkg::ERR_ZERO_DEN},
         '{rfa_pkg::MODE_ADD, 1, 1, 1, 0, 0, 1, 0, 1, rfa_pkg::ERR_ZERO_DEN},
         '{rfa_pkg::MODE_MAC, 1, 0, 5, 5, 1, 1, 0, 1, rfa_pkg::ERR_ZERO_DEN},
         '{rfa_pkg::MODE_MUL, 32'h7FFF_FFFF, 1, 2, 1, 0, 1, 0, 1, rfa_pkg::ERR_OVERFLOW},
         '{rfa_pkg::MODE_ADD, 32'h7FFF_FFFF, 1, 1, 1, 0, 1, 0, 1, rfa_pkg::ERR_OVERFLOW},
         '{rfa_pkg::MODE_ADD, 32'h8000_0000, 1, 0, 1, 0, 1, 32'h8000_0000, 1,
           rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 0, 1, 0, 1,
           rfa_pkg::ERR_OVERFLOW},
         '{rfa_pkg::MODE_MUL, 3, -6, 4, 1, 0, 1, -2, 1, rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_MUL, 1, 32'h8000_0000, 1, 1, 0, 0, 0, 0, 0},
         '{rfa_pkg::MODE_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE, 0, 0, 0, 0, 0},
         '{2'd3, 5, 7, -7, 5, 0, 1, -1, 1, rfa_pkg::ERR_NONE},
         '{2'd3, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, -1, 1, 0, 0, 0, 0},
         '{rfa_pkg::MODE_MAC, 1, 2, 1, 3, 0, 1, 1, 6, rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_MAC, 1, 2, 1, 2, 0, 1, 5, 12, rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_MAC, 32'h7FFF_FFFF, 1, 3, 1, 0, 1, 0, 1, rfa_pkg::ERR_OVERFLOW},
         '{rfa_pkg::MODE_MAC, 1, 4, 1, 1, 1, 1, 2, 3, rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_MAC, 32'h7FFF_FFFF, 1, 1, 1, 0, 1, 32'h7FFF_FFFF, 1,
           rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_MAC, 1, 1, 1, 1, 1, 1, 0, 1, rfa_pkg::ERR_OVERFLOW},
         '{rfa_pkg::MODE_MAC, -1, 1, 1, 1, 1, 1, -1, 1, rfa_pkg::ERR_NONE},
         '{rfa_pkg::MODE_ADD, -1, -1, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (table_rows[i]) send_request(table_rows[i]);
      for (k = 0; k < 700; k++) begin
         case (k / 175)
            0: begin req_idle = 0;  rsp_stall = 0;  end
            1: begin req_idle = 77; rsp_stall = 0;  end
            2: begin req_idle = 0;  rsp_stall = 77; end
            default: begin req_idle = 23; rsp_stall = 23; end
         endcase
         q.mode = rfa_pkg::MODE_W'($urandom_range(3));
         if ($urandom_range(3) == 0) q.mode = rfa_pkg::MODE_MAC;
         q.an = rand_val();
         q.ad = rand_val();
         q.bn = rand_val();
         q.bd = rand_val();
         if (q.mode == rfa_pkg::MODE_MAC && $urandom_range(1)) begin
            q.an = $urandom_range(40) - 20;
            q.bn = $urandom_range(40) - 20;
            q.ad = $urandom_range(12) + 1;
            q.bd = $urandom_range(12) + 1;
         end
         q.last = ($urandom_range(2) == 0);
         q.chk = 0;
         q.en = 0;
         q.ed = 0;
         q.ee = rfa_pkg::ERR_NONE;
         send_request(q);
      end
      req_bus.valid <= 0;
      rsp_stall = 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (errors == 0 && pending.size() == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #50000000;
      $display("tb_top: FAIL");
      $finish;
   end
endmodule
